### rtl/plt_pkg.sv
// shared types and constants for the playlist timeline locator
package plt_pkg;

  localparam int MAX_FILES_DEF = 16;
  localparam int TIMEW = 44;
  localparam int DURW  = 40;
  localparam int TOTW  = 44;
  localparam int ELW   = 54;
  localparam int REMW  = 45;
  localparam int IDXOW = 4;

  localparam logic [DURW-1:0] UNKNOWN_US   = 40'd1800000000;
  localparam logic [DURW-1:0] LOOP_HIGH_US = 40'd60000000;
  localparam logic [DURW-1:0] LOOP_LOW_US  = 40'd5000000;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic CFG_LOOP_ENABLE = 1'b0;
  localparam logic CFG_START_MS    = 1'b1;

  typedef struct packed {
    logic clear;
    logic append;
    logic tick_start;
    logic elap;
    logic div_step;
    logic scan_cmp;
    logic finish;
  } plt_cmd_t;

  typedef struct packed {
    logic no_timeline;
    logic count_zero;
    logic div_needed;
    logic div_last;
    logic scan_last;
    logic hit;
  } plt_stat_t;

endpackage

### rtl/plt_ram.sv
// generic single write port ram with registered read
module plt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/plt_ctrl.sv
// controller state machine for the timeline locator
module plt_ctrl import plt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] opcode,
  input  plt_stat_t  stat,
  output plt_cmd_t   cmd,
  output logic       busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ELAP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_CLEAR:  cmd.clear = 1'b1;
            OP_APPEND: cmd.append = 1'b1;
            OP_TICK: begin
              if (!stat.no_timeline) begin
                cmd.tick_start = 1'b1;
                state_nxt = S_ELAP;
              end
            end
            default: ;
          endcase
        end
      end
      S_ELAP: begin
        cmd.elap = 1'b1;
        if (stat.count_zero) state_nxt = S_FIN;
        else if (stat.div_needed) state_nxt = S_DIV;
        else state_nxt = S_RD;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (stat.hit || stat.scan_last) state_nxt = S_FIN;
        else state_nxt = S_RD;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/plt_dp.sv
// datapath: duration table, elapsed time, serial modulo, clip scan
module plt_dp import plt_pkg::*; #(
  parameter int MAX_FILES = MAX_FILES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  plt_cmd_t          cmd,
  output plt_stat_t         stat,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TIMEW-1:0]  cfg_wdata,
  input  logic [DURW-1:0]   in_duration_us,
  input  logic [TIMEW-1:0]  in_now_ms,
  output logic              out_valid,
  output logic [IDXOW-1:0]  out_file_index,
  output logic [DURW-1:0]   out_offset_us,
  output logic              out_switch_file,
  output logic              out_loop_seek,
  output logic              out_table_full
);

  localparam int IDXW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CW   = $clog2(MAX_FILES + 1);
  localparam int DCW  = $clog2(ELW);

  logic              loop_en_r;
  logic [TIMEW-1:0]  start_ms_r;
  logic [CW-1:0]     count_r;
  logic [TOTW-1:0]   total_r;
  logic [IDXOW-1:0]  cur_r;
  logic [DURW-1:0]   prev_r;
  logic [TIMEW-1:0]  diff_r;
  logic [ELW-1:0]    el_r;
  logic [REMW-1:0]   rem_r;
  logic [DCW-1:0]    dcnt_r;
  logic [ELW-1:0]    acc_r;
  logic [CW-1:0]     si_r;
  logic              found_r;
  logic [IDXW-1:0]   fidx_r;
  logic [DURW-1:0]   foff_r;
  logic [DURW-1:0]   last_d_r;
  logic              ov_r;
  logic [IDXOW-1:0]  oidx_r;
  logic [DURW-1:0]   ooff_r;
  logic              osw_r, ols_r, ofull_r;

  logic [DURW-1:0]   rdata, app_d;
  logic              full, ram_we;
  logic [TOTW:0]     tot_sum;
  logic [ELW-1:0]    el_mul;
  logic [REMW-1:0]   rem_sh, rem_sub;
  logic              rem_ge;
  logic [ELW:0]      acc_sum;
  logic [CW-1:0]     cnt_m1;
  logic [IDXW-1:0]   idx_sel;
  logic [DURW-1:0]   off_sel;
  logic [IDXW+IDXOW-1:0] idx_ext;
  logic [IDXOW-1:0]  idx4;
  logic              ls;

  assign full    = (count_r >= CW'(MAX_FILES));
  assign app_d   = (in_duration_us == '0) ? UNKNOWN_US : in_duration_us;
  assign ram_we  = cmd.append && !full;
  assign tot_sum = {1'b0, total_r} + {{(TOTW+1-DURW){1'b0}}, app_d};

  assign el_mul = {diff_r, 10'b0} - {6'b0, diff_r, 4'b0} - {7'b0, diff_r, 3'b0};

  assign rem_sh  = {rem_r[REMW-2:0], el_r[ELW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, total_r});
  assign rem_sub = rem_sh - {1'b0, total_r};

  assign acc_sum = {1'b0, acc_r} + {{(ELW+1-DURW){1'b0}}, rdata};
  assign cnt_m1  = count_r - 1'b1;

  plt_ram #(.WIDTH(DURW), .DEPTH(MAX_FILES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDXW-1:0]),
    .wdata (app_d),
    .raddr (si_r[IDXW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    stat.no_timeline = (start_ms_r == '0);
    stat.count_zero  = (count_r == '0);
    stat.div_needed  = loop_en_r && (total_r != '0);
    stat.div_last    = (dcnt_r == DCW'(ELW - 1));
    stat.scan_last   = (si_r == cnt_m1);
    stat.hit         = ({1'b0, el_r} < acc_sum);
  end

  always_comb begin
    if (found_r) begin
      idx_sel = fidx_r;
      off_sel = foff_r;
    end else if (count_r == '0 || (loop_en_r && total_r != '0)) begin
      idx_sel = '0;
      off_sel = '0;
    end else begin
      idx_sel = cnt_m1[IDXW-1:0];
      off_sel = last_d_r;
    end
    idx_ext = {{IDXOW{1'b0}}, idx_sel};
    idx4    = idx_ext[IDXOW-1:0];
    ls = loop_en_r && (idx4 == '0) && (cur_r == '0) &&
         (prev_r > LOOP_HIGH_US) && (off_sel < LOOP_LOW_US);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_en_r  <= 1'b1;
      start_ms_r <= '0;
      count_r    <= '0;
      total_r    <= '0;
      cur_r      <= '0;
      prev_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_LOOP_ENABLE) loop_en_r <= cfg_wdata[0];
        else start_ms_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        count_r <= '0;
        total_r <= '0;
      end
      if (cmd.append) begin
        ov_r    <= 1'b1;
        oidx_r  <= '0;
        ooff_r  <= '0;
        osw_r   <= 1'b0;
        ols_r   <= 1'b0;
        ofull_r <= full;
        if (!full) begin
          count_r <= count_r + 1'b1;
          total_r <= tot_sum[TOTW] ? {TOTW{1'b1}} : tot_sum[TOTW-1:0];
        end
      end
      if (cmd.finish) begin
        ov_r    <= 1'b1;
        oidx_r  <= idx4;
        ooff_r  <= off_sel;
        osw_r   <= (idx4 != cur_r);
        ols_r   <= ls;
        ofull_r <= 1'b0;
        cur_r   <= idx4;
        prev_r  <= off_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      diff_r <= (in_now_ms >= start_ms_r) ? in_now_ms - start_ms_r : '0;
    end
    if (cmd.elap) begin
      el_r    <= el_mul;
      rem_r   <= '0;
      dcnt_r  <= '0;
      acc_r   <= '0;
      si_r    <= '0;
      found_r <= 1'b0;
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      rem_r  <= rem_ge ? rem_sub : rem_sh;
      if (stat.div_last) begin
        el_r <= {{(ELW-REMW){1'b0}}, (rem_ge ? rem_sub : rem_sh)};
      end else begin
        el_r <= {el_r[ELW-2:0], 1'b0};
      end
    end
    if (cmd.scan_cmp) begin
      last_d_r <= rdata;
      if (stat.hit) begin
        found_r <= 1'b1;
        fidx_r  <= si_r[IDXW-1:0];
        foff_r  <= DURW'(el_r - acc_r);
      end else begin
        acc_r <= acc_sum[ELW-1:0];
        si_r  <= si_r + 1'b1;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_file_index  = oidx_r;
  assign out_offset_us   = ooff_r;
  assign out_switch_file = osw_r;
  assign out_loop_seek   = ols_r;
  assign out_table_full  = ofull_r;

endmodule

### rtl/playlist_timeline_locator_unit.sv
// playlist timeline locator top level
// clear and append run without raising busy; append result strobes on the next cycle
// a tick runs elapsed time, serial modulo (looping only), then read and compare per entry
// one item at a time: busy stays high while a tick runs through modulo and scan
// results show for one cycle on out_valid; the receiver cannot stall
// synchronous active-low reset clears the table count, total, current clip and out_valid
module playlist_timeline_locator_unit import plt_pkg::*; #(
  parameter int MAX_FILES = MAX_FILES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [DURW-1:0]   in_duration_us,
  input  logic [TIMEW-1:0]  in_now_ms,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TIMEW-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [IDXOW-1:0]  out_file_index,
  output logic [DURW-1:0]   out_offset_us,
  output logic              out_switch_file,
  output logic              out_loop_seek,
  output logic              out_table_full
);

  plt_cmd_t  cmd;
  plt_stat_t stat;

  plt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  plt_dp #(.MAX_FILES(MAX_FILES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_duration_us  (in_duration_us),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_file_index  (out_file_index),
    .out_offset_us   (out_offset_us),
    .out_switch_file (out_switch_file),
    .out_loop_seek   (out_loop_seek),
    .out_table_full  (out_table_full)
  );

endmodule

### tb/playlist_timeline_locator_unit_tb.sv
// self-checking testbench for the playlist timeline locator, directed table and ticks then random items
module playlist_timeline_locator_unit_tb;
  import plt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDIR = 22;
  localparam int NRAND = 1400;
  localparam longint LIMIT = 1200000;

  typedef struct packed {
    logic [IDXOW-1:0] file_index;
    logic [DURW-1:0]  offset_us;
    logic             switch_file;
    logic             loop_seek;
    logic             table_full;
  } locate_t;

  typedef struct {
    logic [1:0]       op;
    logic [DURW-1:0]  dur;
    logic [TIMEW-1:0] now;
    logic             has_fixed;
    locate_t          fixed;
  } dir_row_t;

  logic clk, rst_n, start, busy, cfg_we, cfg_index;
  logic [1:0] in_opcode;
  logic [DURW-1:0] in_duration_us;
  logic [TIMEW-1:0] in_now_ms, cfg_wdata;
  logic out_valid, out_switch_file, out_loop_seek, out_table_full;
  logic [IDXOW-1:0] out_file_index;
  logic [DURW-1:0] out_offset_us;

  playlist_timeline_locator_unit dut (.*);

  // predictor state
  logic [DURW-1:0] clip_dur [16];
  int unsigned clip_count;
  logic [TOTW-1:0] total_us;
  logic [IDXOW-1:0] cur_clip;
  logic [DURW-1:0] last_offset;
  logic loop_en;
  logic [TIMEW-1:0] start_ms;

  locate_t pending_locs[$];
  int errors, mismatches;
  longint cycles;
  bit use_gaps;
  dir_row_t dir_rows[NDIR];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic void predict_item(input logic [1:0] op, input logic [DURW-1:0] dur,
                                       input logic [TIMEW-1:0] now);
    locate_t r;
    logic [63:0] el, acc, tot;
    logic [DURW-1:0] d, off;
    int unsigned idx;
    bit found;
    r = '0;
    if (op == OP_CLEAR) begin
      clip_count = 0;
      total_us = '0;
    end else if (op == OP_APPEND) begin
      d = (dur == 0) ? UNKNOWN_US : dur;
      if (clip_count >= 16) r.table_full = 1'b1;
      else begin
        clip_dur[clip_count] = d;
        clip_count++;
        tot = 64'(total_us) + 64'(d);
        total_us = (tot > 64'hFFF_FFFF_FFFF) ? '1 : tot[TOTW-1:0];
      end
      pending_locs.push_back(r);
    end else if (op == OP_TICK && start_ms != 0) begin
      idx = 0;
      off = '0;
      if (clip_count != 0) begin
        el = (now >= start_ms) ? (64'(now) - 64'(start_ms)) * 64'd1000 : 64'd0;
        if (loop_en && total_us != 0) el = el % 64'(total_us);
        acc = 0;
        found = 0;
        for (int i = 0; i < clip_count; i++) begin
          if (!found && el < acc + 64'(clip_dur[i])) begin
            idx = i;
            off = DURW'(el - acc);
            found = 1;
          end
          if (!found) acc += 64'(clip_dur[i]);
        end
        if (!found && !(loop_en && total_us != 0)) begin
          idx = clip_count - 1;
          off = clip_dur[clip_count - 1];
        end
      end
      r.file_index = IDXOW'(idx);
      r.offset_us = off;
      r.loop_seek = loop_en && r.file_index == 0 && cur_clip == 0 &&
                    last_offset > LOOP_HIGH_US && off < LOOP_LOW_US;
      r.switch_file = r.file_index != cur_clip;
      last_offset = off;
      cur_clip = r.file_index;
      pending_locs.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    locate_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_file_index, out_offset_us, out_switch_file, out_loop_seek, out_table_full};
      if (pending_locs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_locs.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic gap();
    if (use_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [DURW-1:0] dur,
                           input logic [TIMEW-1:0] now);
    gap();
    in_opcode <= op;
    in_duration_us <= dur;
    in_now_ms <= now;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(op, dur, now);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_locs.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [TIMEW-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_LOOP_ENABLE) loop_en = val[0];
    else start_ms = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DURW-1:0] rand_dur();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DURW'({$urandom, $urandom});
      2: return DURW'($urandom_range(1, 100));
      default: return DURW'($urandom_range(1000000, 90000000));
    endcase
  endfunction

  function automatic logic [TIMEW-1:0] rand_now();
    case ($urandom_range(0, 4))
      0: return TIMEW'({$urandom, $urandom});
      1: return start_ms - TIMEW'($urandom_range(0, 1000));
      default: return start_ms + TIMEW'($urandom_range(0, 2000000));
    endcase
  endfunction

  initial begin
    locate_t z;
    z = '0;
    errors = 0;
    mismatches = 0;
    use_gaps = 1;
    clip_count = 0;
    total_us = '0;
    cur_clip = '0;
    last_offset = '0;
    loop_en = 1'b1;
    start_ms = '0;
    foreach (clip_dur[i]) clip_dur[i] = '0;
    rst_n = 0;
    start = 0;
    in_opcode = OP_CLEAR;
    in_duration_us = '0;
    in_now_ms = '0;
    cfg_we = 0;
    cfg_index = CFG_LOOP_ENABLE;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    dir_rows[0] = '{OP_TICK, '0, 44'd5, 1'b0, z};
    dir_rows[1] = '{2'd3, '1, '1, 1'b0, z};
    dir_rows[2] = '{OP_APPEND, '0, '0, 1'b1, z};
    dir_rows[3] = '{OP_APPEND, '1, '0, 1'b1, z};
    dir_rows[4] = '{OP_APPEND, 40'd1, '0, 1'b1, z};
    for (int i = 5; i < 18; i++) dir_rows[i] = '{OP_APPEND, 40'd70000000, '0, 1'b1, z};
    dir_rows[18] = '{OP_APPEND, 40'd7, '0, 1'b1, z};
    dir_rows[18].fixed.table_full = 1'b1;
    dir_rows[19] = '{OP_CLEAR, '0, '0, 1'b0, z};
    dir_rows[20] = '{OP_APPEND, 40'd61000000, '0, 1'b1, z};
    dir_rows[21] = '{OP_APPEND, 40'd2000000, '0, 1'b1, z};
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].dur, dir_rows[i].now);
      if (dir_rows[i].has_fixed && pending_locs.size() != 0 &&
          pending_locs[$] !== dir_rows[i].fixed) begin
        errors++;
        $display("row %0d: table expects %p, predictor %p", i, dir_rows[i].fixed, pending_locs[$]);
      end
    end

    // ticks around the loop point, behind start, and on empty table
    write_cfg(CFG_START_MS, 44'd1000);
    send_item(OP_TICK, '0, 44'd0);
    send_item(OP_TICK, '0, 44'd62000);
    send_item(OP_TICK, '0, 44'd64000);
    send_item(OP_TICK, '0, 44'd63000);
    send_item(OP_TICK, '0, '1);
    write_cfg(CFG_LOOP_ENABLE, TIMEW'(1'b0));
    send_item(OP_TICK, '0, '1);
    send_item(OP_TICK, '0, 44'd62500);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_TICK, '0, 44'd99999);
    write_cfg(CFG_START_MS, '1);
    send_item(OP_TICK, '0, '1);

    for (int n = 0; n < NRAND; n++) begin
      int k;
      if (n > NRAND - 150) use_gaps = 0;
      if (n % 100 == 0) begin
        if ($urandom_range(0, 1)) write_cfg(CFG_LOOP_ENABLE, TIMEW'($urandom_range(0, 1)));
        case ($urandom_range(0, 4))
          0: write_cfg(CFG_START_MS, '0);
          1: write_cfg(CFG_START_MS, '1);
          default: write_cfg(CFG_START_MS, TIMEW'({$urandom, $urandom}));
        endcase
      end
      k = $urandom_range(0, 19);
      if (k == 0) send_item(OP_CLEAR, rand_dur(), rand_now());
      else if (k == 1) send_item(2'd3, rand_dur(), rand_now());
      else if (k < 7 || clip_count == 0) send_item(OP_APPEND, rand_dur(), rand_now());
      else send_item(OP_TICK, rand_dur(), rand_now());
    end

    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
